[rtl/core/wsp_pkg.sv]
// Shared types and constants for the world-to-screen projection pipeline.
// Used by the divider lane and by the top level; no dependencies.
package wsp_pkg;

  localparam int NUM_W    = 92;  // |clip| (62 bits) times size*2^15 (30 bits)
  localparam int DEN_W    = 62;  // positive clip w
  localparam int QUO_W    = 41;  // quotient, clamped to 2^40
  localparam int DIV_BITS = 40;  // quotient bits formed one per stage

  localparam logic signed [63:0] W_MIN_Q34 = 64'sd17179869;
  localparam logic [QUO_W-1:0]   Q_LIMIT   = {1'b1, {(QUO_W-1){1'b0}}};

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [QUO_W-1:0] quo_t;

  // Per-transaction side data that travels beside the dividers.
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } tag_t;

  typedef enum logic [2:0] {
    REG_XROW01 = 3'd0,
    REG_XROW23 = 3'd1,
    REG_YROW01 = 3'd2,
    REG_YROW23 = 3'd3,
    REG_WROW01 = 3'd4,
    REG_WROW23 = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } reg_idx_t;

endpackage

[rtl/core/wsp_div.sv]
// Pipelined restoring divider lane: trunc(num/den) clamped to 2^40.
// Depends on wsp_pkg; one quotient bit per register stage.
module wsp_div (
  input  logic          clk,
  input  wsp_pkg::num_t num,
  input  wsp_pkg::den_t den,
  output wsp_pkg::quo_t quo
);
  import wsp_pkg::*;

  logic [DEN_W-1:0]    rem   [DIV_BITS+1];
  logic [DIV_BITS-1:0] low   [DIV_BITS+1];
  logic [DIV_BITS-1:0] qb    [DIV_BITS+1];
  logic [DEN_W-1:0]    dens  [DIV_BITS+1];
  logic                clamp [DIV_BITS+1];

  // If the quotient reaches 2^40 the result is the clamp value; otherwise the
  // high part of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    clamp[0] <= {10'b0, num} >= {den, {DIV_BITS{1'b0}}};
    rem[0]   <= {{(DEN_W-(NUM_W-DIV_BITS)){1'b0}}, num[NUM_W-1:DIV_BITS]};
    low[0]   <= num[DIV_BITS-1:0];
    qb[0]    <= '0;
    dens[0]  <= den;
  end

  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_step
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    logic           ge;
    always_comb begin
      r2   = {rem[i-1], low[i-1][DIV_BITS-1]};
      diff = r2 - {1'b0, dens[i-1]};
      ge   = r2 >= {1'b0, dens[i-1]};
    end
    always_ff @(posedge clk) begin
      rem[i]   <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      low[i]   <= {low[i-1][DIV_BITS-2:0], 1'b0};
      qb[i]    <= {qb[i-1][DIV_BITS-2:0], ge};
      dens[i]  <= dens[i-1];
      clamp[i] <= clamp[i-1];
    end
  end

  assign quo = clamp[DIV_BITS] ? Q_LIMIT : {1'b0, qb[DIV_BITS]};

endmodule

[rtl/core/world_to_screen_projection_unit.sv]
// Top level of the world-to-screen projection pipeline.
// Depends on wsp_pkg and instantiates two wsp_div lanes.

// A new point is accepted in every cycle (busy stays low). Its result comes out
// as a one-cycle done strobe after 47 register stages in a row: the input
// capture register, four arithmetic stages ahead of the dividers, the 41
// stages of the bit-per-stage dividers and the output register. The receiver
// cannot stall, so results must be taken as they come. The user must write
// configuration only while no transaction is in flight; the block itself
// does not enforce this.
module world_to_screen_projection_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic               visible,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y
);
  import wsp_pkg::*;

  logic [63:0] xr01, xr23, yr01, yr23, wr01, wr23;
  logic [14:0] scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      xr01 <= '0; xr23 <= '0; yr01 <= '0; yr23 <= '0; wr01 <= '0; wr23 <= '0;
      scr_w <= 15'd1920;
      scr_h <= 15'd1080;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_XROW01: xr01 <= cfg_data;
        REG_XROW23: xr23 <= cfg_data;
        REG_YROW01: yr01 <= cfg_data;
        REG_YROW23: yr23 <= cfg_data;
        REG_WROW01: wr01 <= cfg_data;
        REG_WROW23: wr23 <= cfg_data;
        REG_WIDTH:  scr_w <= cfg_data[14:0];
        REG_HEIGHT: scr_h <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: capture the point.
  logic               v1;
  logic signed [31:0] px, py, pz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
    px <= world_x; py <= world_y; pz <= world_z;
  end

  // Stage 2: the nine coefficient products.
  logic               v2;
  logic signed [63:0] pr [9];
  logic signed [31:0] c3x, c3y, c3w, c3x2, c3y2, c3w2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    pr[0] <= $signed(xr01[31:0])  * px;
    pr[1] <= $signed(xr01[63:32]) * py;
    pr[2] <= $signed(xr23[31:0])  * pz;
    pr[3] <= $signed(yr01[31:0])  * px;
    pr[4] <= $signed(yr01[63:32]) * py;
    pr[5] <= $signed(yr23[31:0])  * pz;
    pr[6] <= $signed(wr01[31:0])  * px;
    pr[7] <= $signed(wr01[63:32]) * py;
    pr[8] <= $signed(wr23[31:0])  * pz;
    c3x <= $signed(xr23[63:32]);
    c3y <= $signed(yr23[63:32]);
    c3w <= $signed(wr23[63:32]);
  end
  assign c3x2 = c3x;
  assign c3y2 = c3y;
  assign c3w2 = c3w;

  // Stage 3: clip coordinates in Q30.34; the shift floors each product.
  logic               v3;
  logic signed [63:0] cx, cy, cw;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    cx <= (pr[0] >>> 2) + (pr[1] >>> 2) + (pr[2] >>> 2) + (64'(c3x2) <<< 14);
    cy <= (pr[3] >>> 2) + (pr[4] >>> 2) + (pr[5] >>> 2) + (64'(c3y2) <<< 14);
    cw <= (pr[6] >>> 2) + (pr[7] >>> 2) + (pr[8] >>> 2) + (64'(c3w2) <<< 14);
  end

  // Stage 4: magnitudes times size*2^15, split into two partial products.
  logic        v4;
  tag_t        tag4;
  den_t        den4;
  logic [63:0] mx, my;
  logic [29:0] kx, ky;
  logic [60:0] plx, phx, ply, phy;
  assign mx = cx[63] ? 64'(-cx) : 64'(cx);
  assign my = cy[63] ? 64'(-cy) : 64'(cy);
  assign kx = {scr_w, 15'b0};
  assign ky = {scr_h, 15'b0};
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    tag4.vis   <= cw > W_MIN_Q34;
    tag4.neg_x <= cx[63];
    tag4.neg_y <= cy[63];
    den4 <= cw[DEN_W-1:0];
    plx  <= mx[30:0]  * kx;
    phx  <= mx[61:31] * kx;
    ply  <= my[30:0]  * ky;
    phy  <= my[61:31] * ky;
  end

  // Stage 5: full numerators.
  logic v5;
  tag_t tag5;
  den_t den5;
  num_t nx, ny;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    tag5 <= tag4;
    den5 <= den4;
    nx <= {phx, 31'b0} + {31'b0, plx};
    ny <= {phy, 31'b0} + {31'b0, ply};
  end

  quo_t qx, qy;
  wsp_div u_div_x (.clk(clk), .num(nx), .den(den5), .quo(qx));
  wsp_div u_div_y (.clk(clk), .num(ny), .den(den5), .quo(qy));

  // Side data and valid bits follow the divider lanes stage by stage.
  logic vd [DIV_BITS+1];
  tag_t td [DIV_BITS+1];
  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else     vd[0] <= v5;
    td[0] <= tag5;
  end
  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) vd[i] <= 1'b0;
      else     vd[i] <= vd[i-1];
      td[i] <= td[i-1];
    end
  end

  // Output stage: sign, viewport offsets, saturation and zeroing of points that are not visible.
  logic signed [47:0] vx, vy, sxv, syv;
  logic signed [31:0] sx_sat, sy_sat;
  assign vx  = td[DIV_BITS].neg_x ? -$signed(48'(qx)) : $signed(48'(qx));
  assign vy  = td[DIV_BITS].neg_y ? -$signed(48'(qy)) : $signed(48'(qy));
  assign sxv = $signed({18'b0, scr_w[14:1], 16'b0}) + vx + 48'sd32768;
  assign syv = $signed({18'b0, scr_h[14:1], 16'b0}) - (vy + 48'sd32768);
  always_comb begin
    if (sxv > 48'sd2147483647)       sx_sat = 32'sh7fffffff;
    else if (sxv < -48'sd2147483648) sx_sat = 32'sh80000000;
    else                             sx_sat = sxv[31:0];
    if (syv > 48'sd2147483647)       sy_sat = 32'sh7fffffff;
    else if (syv < -48'sd2147483648) sy_sat = 32'sh80000000;
    else                             sy_sat = syv[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[DIV_BITS];
    visible  <= td[DIV_BITS].vis;
    screen_x <= td[DIV_BITS].vis ? sx_sat : 32'sd0;
    screen_y <= td[DIV_BITS].vis ? sy_sat : 32'sd0;
  end

endmodule
